>>> rtl/core/npbt_pkg.sv
// shared constants, types and helpers of the nearest point table
`default_nettype none

package npbt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COORD_WIDTH = 20;

  localparam int OP_W     = 2;
  localparam int HANDLE_W = 8;
  localparam int POS_W    = 20;
  localparam int RANGE_W  = 19;
  localparam int STATUS_W = 2;
  localparam int DIST_W   = 40;

  localparam int EXT_W = (COORD_WIDTH > POS_W) ? COORD_WIDTH : POS_W;
  localparam int CMP_W = (COORD_WIDTH > RANGE_W) ? COORD_WIDTH : RANGE_W;
  localparam int MAG_W = (COORD_WIDTH < RANGE_W) ? COORD_WIDTH : RANGE_W;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 3);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd2;

  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_HOLD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MARK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DROP   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SORT   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_ROTATE = 3'd6;

  typedef struct packed {
    logic [HANDLE_W-1:0]    id;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] z;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic                   phase;
    logic [HANDLE_W-1:0]    handle;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] z;
  } cell_ctl_t;

  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] handle;
    logic [DIST_W-1:0]   dist_sq;
  } scan_res_t;

  function automatic logic [COORD_WIDTH-1:0] to_coord(input logic [POS_W-1:0] p);
    logic [EXT_W-1:0] t;
    t = EXT_W'(p);
    return t[COORD_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/npbt_cell.sv
// one table cell: entry storage, occupancy, handle match and neighbor moves
`default_nettype none

module npbt_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire npbt_pkg::cell_ctl_t ctl,
  input  wire logic               odd,
  input  wire npbt_pkg::entry_t   up_data,
  input  wire logic               up_valid,
  input  wire logic               up_keep,
  input  wire npbt_pkg::entry_t   down_data,
  input  wire logic               down_keep,
  output npbt_pkg::entry_t        data,
  output logic                    valid,
  output logic                    match
);

  logic lower;

  assign lower = (odd == ctl.phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      case (ctl.cmd)
        npbt_pkg::CMD_INSERT: begin
          if (!valid && down_keep) begin
            valid <= 1'b1;
          end
        end
        npbt_pkg::CMD_MARK: begin
          match <= valid && (data.id == ctl.handle);
        end
        npbt_pkg::CMD_DROP: begin
          if (match) begin
            valid <= 1'b0;
          end
        end
        npbt_pkg::CMD_SORT: begin
          if (lower && !valid && up_keep) begin
            valid <= 1'b1;
          end else if (!lower && valid && !down_keep) begin
            valid <= 1'b0;
          end
        end
        npbt_pkg::CMD_ROTATE: begin
          valid <= up_valid;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      npbt_pkg::CMD_INSERT: begin
        if (!valid && down_keep) begin
          data.id <= ctl.handle;
          data.x  <= ctl.x;
          data.y  <= ctl.y;
          data.z  <= ctl.z;
        end
      end
      npbt_pkg::CMD_UPDATE: begin
        if (match) begin
          data.x <= ctl.x;
          data.y <= ctl.y;
          data.z <= ctl.z;
        end
      end
      npbt_pkg::CMD_SORT: begin
        if (lower && !valid && up_keep) begin
          data <= up_data;
        end else if (!lower && valid && !down_keep) begin
          data <= down_data;
        end
      end
      npbt_pkg::CMD_ROTATE: begin
        data <= up_data;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/npbt_scan.sv
// pipelined box test, squared distance and running nearest pick
`default_nettype none

module npbt_scan (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic                                   feed,
  input  wire npbt_pkg::entry_t                       entry,
  input  wire logic [npbt_pkg::COORD_WIDTH-1:0]       qx,
  input  wire logic [npbt_pkg::COORD_WIDTH-1:0]       qy,
  input  wire logic [npbt_pkg::COORD_WIDTH-1:0]       qz,
  input  wire logic [npbt_pkg::RANGE_W-1:0]           rx,
  input  wire logic [npbt_pkg::RANGE_W-1:0]           ry,
  input  wire logic [npbt_pkg::RANGE_W-1:0]           rz,
  output npbt_pkg::scan_res_t                         res
);

  localparam int CW = npbt_pkg::COORD_WIDTH;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] d;
    logic [CW:0] n;
    d = {a[CW-1], a} - {b[CW-1], b};
    n = ~d + 1'b1;
    return d[CW] ? n[CW-1:0] : d[CW-1:0];
  endfunction

  logic [CW-1:0] dx, dy, dz;
  logic          in_box;

  logic                            v1, v2, v3;
  logic [npbt_pkg::HANDLE_W-1:0]   id1, id2, id3;
  logic [npbt_pkg::MAG_W-1:0]      mx1, my1, mz1;
  logic [npbt_pkg::SQ_W-1:0]       sx2, sy2, sz2;
  logic [npbt_pkg::SUM_W-1:0]      sum3;
  logic [npbt_pkg::SUM_W-1:0]      best;
  logic                            best_found;
  logic [npbt_pkg::HANDLE_W-1:0]   best_handle;

  always_comb begin
    dx = abs_diff(qx, entry.x);
    dy = abs_diff(qy, entry.y);
    dz = abs_diff(qz, entry.z);
    in_box = (npbt_pkg::CMP_W'(dx) <= npbt_pkg::CMP_W'(rx))
          && (npbt_pkg::CMP_W'(dy) <= npbt_pkg::CMP_W'(ry))
          && (npbt_pkg::CMP_W'(dz) <= npbt_pkg::CMP_W'(rz));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      best_found <= 1'b0;
    end else begin
      v1 <= feed && in_box;
      v2 <= v1;
      v3 <= v2;
      if (start) begin
        best_found <= 1'b0;
      end else if (v3 && (!best_found || sum3 < best)) begin
        best_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    id1  <= entry.id;
    mx1  <= dx[npbt_pkg::MAG_W-1:0];
    my1  <= dy[npbt_pkg::MAG_W-1:0];
    mz1  <= dz[npbt_pkg::MAG_W-1:0];
    id2  <= id1;
    sx2  <= npbt_pkg::SQ_W'(mx1) * npbt_pkg::SQ_W'(mx1);
    sy2  <= npbt_pkg::SQ_W'(my1) * npbt_pkg::SQ_W'(my1);
    sz2  <= npbt_pkg::SQ_W'(mz1) * npbt_pkg::SQ_W'(mz1);
    id3  <= id2;
    sum3 <= npbt_pkg::SUM_W'(sx2) + npbt_pkg::SUM_W'(sy2) + npbt_pkg::SUM_W'(sz2);
    if (start) begin
      best        <= '0;
      best_handle <= '0;
    end else if (v3 && (!best_found || sum3 < best)) begin
      best        <= sum3;
      best_handle <= id3;
    end
  end

  assign res = {best_found, best_handle, npbt_pkg::DIST_W'(best)};

endmodule

`default_nettype wire

>>> rtl/core/nearest_point_in_box_table.sv
// top level: command sequencer, row of table cells and nearest point scan
//
// channel  | handshake            | payload
// command  | cmd_valid, cmd_stall | operation, handle, pos_x/y/z, range_x/y/z
// result   | res_valid, res_stall | status, found, nearest_handle, nearest_dist_sq
//
// insert goes from acceptance through EXEC and FINISH to the result register; update also passes APPLY
// remove passes EXEC, APPLY and then SORT, whose odd-even shuffle closes gaps
// query passes EXEC and then SCAN, which makes one full rotation of the cell ring
// one transaction at a time; a new one is taken while the last result waits
// reset clears occupancy and match flags; entry contents need no clearing pass
`default_nettype none

module nearest_point_in_box_table (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cmd_valid,
  output logic                                     cmd_stall,
  input  wire logic [npbt_pkg::OP_W-1:0]           operation,
  input  wire logic [npbt_pkg::HANDLE_W-1:0]       handle,
  input  wire logic signed [npbt_pkg::POS_W-1:0]   pos_x,
  input  wire logic signed [npbt_pkg::POS_W-1:0]   pos_y,
  input  wire logic signed [npbt_pkg::POS_W-1:0]   pos_z,
  input  wire logic [npbt_pkg::RANGE_W-1:0]        range_x,
  input  wire logic [npbt_pkg::RANGE_W-1:0]        range_y,
  input  wire logic [npbt_pkg::RANGE_W-1:0]        range_z,
  output logic                                     res_valid,
  input  wire logic                                res_stall,
  output logic [npbt_pkg::STATUS_W-1:0]            status,
  output logic                                     found,
  output logic [npbt_pkg::HANDLE_W-1:0]            nearest_handle,
  output logic [npbt_pkg::DIST_W-1:0]              nearest_dist_sq
);

  localparam int DEPTH = npbt_pkg::TABLE_DEPTH;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_SORT   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]                       state;
  logic [npbt_pkg::CNT_W-1:0]       cnt;
  logic [npbt_pkg::STATUS_W-1:0]    res_status;

  logic [npbt_pkg::OP_W-1:0]        op;
  logic [npbt_pkg::HANDLE_W-1:0]    op_handle;
  logic [npbt_pkg::COORD_WIDTH-1:0] op_x, op_y, op_z;
  logic [npbt_pkg::RANGE_W-1:0]     op_rx, op_ry, op_rz;

  npbt_pkg::cell_ctl_t  ctl;
  npbt_pkg::entry_t     cell_data  [DEPTH];
  logic [DEPTH-1:0]     cell_valid;
  logic [DEPTH-1:0]     cell_match;
  npbt_pkg::scan_res_t  scan;

  logic rotating;
  logic hit;
  logic full;

  assign cmd_stall = (state != S_IDLE);
  assign rotating  = (state == S_SCAN) && (cnt < npbt_pkg::CNT_W'(DEPTH));
  assign hit       = |cell_match;
  assign full      = cell_valid[DEPTH-1];

  always_comb begin
    ctl.cmd    = npbt_pkg::CMD_HOLD;
    ctl.phase  = cnt[0];
    ctl.handle = op_handle;
    ctl.x      = op_x;
    ctl.y      = op_y;
    ctl.z      = op_z;
    case (state)
      S_EXEC:  ctl.cmd = (op == npbt_pkg::OP_INSERT) ? npbt_pkg::CMD_INSERT
                                                     : npbt_pkg::CMD_MARK;
      S_APPLY: ctl.cmd = (op == npbt_pkg::OP_UPDATE) ? npbt_pkg::CMD_UPDATE
                                                     : npbt_pkg::CMD_DROP;
      S_SORT:  ctl.cmd = npbt_pkg::CMD_SORT;
      S_SCAN:  ctl.cmd = rotating ? npbt_pkg::CMD_ROTATE : npbt_pkg::CMD_HOLD;
      default: ctl.cmd = npbt_pkg::CMD_HOLD;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic up_keep;
    logic down_keep;
    npbt_pkg::entry_t down_data;

    if (i == DEPTH - 1) begin : g_top
      assign up_keep = 1'b0;
    end else begin : g_mid
      assign up_keep = cell_valid[i+1];
    end

    if (i == 0) begin : g_bottom
      assign down_keep = 1'b1;
      assign down_data = cell_data[0];
    end else begin : g_rest
      assign down_keep = cell_valid[i-1];
      assign down_data = cell_data[i-1];
    end

    npbt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .odd       (1'(i % 2)),
      .up_data   (cell_data[(i + 1) % DEPTH]),
      .up_valid  (cell_valid[(i + 1) % DEPTH]),
      .up_keep   (up_keep),
      .down_data (down_data),
      .down_keep (down_keep),
      .data      (cell_data[i]),
      .valid     (cell_valid[i]),
      .match     (cell_match[i])
    );
  end

  npbt_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_EXEC),
    .feed  (rotating && cell_valid[0]),
    .entry (cell_data[0]),
    .qx    (op_x),
    .qy    (op_y),
    .qz    (op_z),
    .rx    (op_rx),
    .ry    (op_ry),
    .rz    (op_rz),
    .res   (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt <= '0;
          case (op)
            npbt_pkg::OP_INSERT: state <= S_FINISH;
            npbt_pkg::OP_QUERY:  state <= S_SCAN;
            default:             state <= S_APPLY;
          endcase
        end
        S_APPLY: begin
          state <= (op == npbt_pkg::OP_UPDATE) ? S_FINISH : S_SORT;
        end
        S_SORT: begin
          cnt <= cnt + 1'b1;
          if (cnt == npbt_pkg::CNT_W'(DEPTH - 1)) begin
            state <= S_FINISH;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == npbt_pkg::CNT_W'(DEPTH + 2)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!res_valid || !res_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      op        <= operation;
      op_handle <= handle;
      op_x      <= npbt_pkg::to_coord(pos_x);
      op_y      <= npbt_pkg::to_coord(pos_y);
      op_z      <= npbt_pkg::to_coord(pos_z);
      op_rx     <= range_x;
      op_ry     <= range_y;
      op_rz     <= range_z;
    end
    if (state == S_EXEC) begin
      res_status <= (op == npbt_pkg::OP_INSERT && full) ? npbt_pkg::STAT_FULL
                                                       : npbt_pkg::STAT_DONE;
    end
    if (state == S_APPLY) begin
      res_status <= hit ? npbt_pkg::STAT_DONE : npbt_pkg::STAT_ABSENT;
    end
    if (state == S_FINISH && (!res_valid || !res_stall)) begin
      status <= res_status;
      if (op == npbt_pkg::OP_QUERY) begin
        found           <= scan.found;
        nearest_handle  <= scan.handle;
        nearest_dist_sq <= scan.dist_sq;
      end else begin
        found           <= 1'b0;
        nearest_handle  <= '0;
        nearest_dist_sq <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/npbt_checker.sv
// checker for the nearest point table: tracks the table, predicts each answer, compares results
module npbt_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cmd_valid,
  input  wire logic                                cmd_stall,
  input  wire logic [npbt_pkg::OP_W-1:0]           operation,
  input  wire logic [npbt_pkg::HANDLE_W-1:0]       handle,
  input  wire logic signed [npbt_pkg::POS_W-1:0]   pos_x,
  input  wire logic signed [npbt_pkg::POS_W-1:0]   pos_y,
  input  wire logic signed [npbt_pkg::POS_W-1:0]   pos_z,
  input  wire logic [npbt_pkg::RANGE_W-1:0]        range_x,
  input  wire logic [npbt_pkg::RANGE_W-1:0]        range_y,
  input  wire logic [npbt_pkg::RANGE_W-1:0]        range_z,
  input  wire logic                                res_valid,
  input  wire logic                                res_stall,
  input  wire logic [npbt_pkg::STATUS_W-1:0]       status,
  input  wire logic                                found,
  input  wire logic [npbt_pkg::HANDLE_W-1:0]       nearest_handle,
  input  wire logic [npbt_pkg::DIST_W-1:0]         nearest_dist_sq,
  output int                                       outstanding,
  output int                                       error_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import npbt_pkg::*;

  localparam int PEND_DEPTH = 16;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [HANDLE_W-1:0] handle;
    logic [DIST_W-1:0]   dist_sq;
  } answer_t;

  logic [HANDLE_W-1:0]           slot_handle [TABLE_DEPTH];
  logic signed [COORD_WIDTH-1:0] slot_x [TABLE_DEPTH];
  logic signed [COORD_WIDTH-1:0] slot_y [TABLE_DEPTH];
  logic signed [COORD_WIDTH-1:0] slot_z [TABLE_DEPTH];
  int                            slot_count;
  answer_t                       expected_answers [PEND_DEPTH];
  int                            wr_ptr;
  int                            rd_ptr;
  answer_t                       want;

  initial begin
    error_count = 0;
    slot_count = 0;
    wr_ptr = 0;
    rd_ptr = 0;
  end

  function automatic longint axis_gap(input logic signed [COORD_WIDTH-1:0] a,
                                      input logic signed [COORD_WIDTH-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic answer_t apply_command(input logic [OP_W-1:0] op,
                                            input logic [HANDLE_W-1:0] h,
                                            input logic signed [POS_W-1:0] px,
                                            input logic signed [POS_W-1:0] py,
                                            input logic signed [POS_W-1:0] pz,
                                            input logic [RANGE_W-1:0] rx,
                                            input logic [RANGE_W-1:0] ry,
                                            input logic [RANGE_W-1:0] rz);
    answer_t ans;
    int      keep;
    bit      hit;
    longint  ax, ay, az, sq;
    ans = '0;
    ans.status = STAT_DONE;
    hit = 1'b0;
    keep = 0;
    case (op)
      OP_INSERT: begin
        if (slot_count >= TABLE_DEPTH) begin
          ans.status = STAT_FULL;
        end else begin
          slot_handle[slot_count] = h;
          slot_x[slot_count] = px;
          slot_y[slot_count] = py;
          slot_z[slot_count] = pz;
          slot_count++;
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < slot_count; i++) begin
          if (slot_handle[i] == h) begin
            hit = 1'b1;
          end else begin
            slot_handle[keep] = slot_handle[i];
            slot_x[keep] = slot_x[i];
            slot_y[keep] = slot_y[i];
            slot_z[keep] = slot_z[i];
            keep++;
          end
        end
        slot_count = keep;
        if (!hit) ans.status = STAT_ABSENT;
      end
      OP_UPDATE: begin
        for (int i = 0; i < slot_count; i++) begin
          if (slot_handle[i] == h) begin
            slot_x[i] = px;
            slot_y[i] = py;
            slot_z[i] = pz;
            hit = 1'b1;
          end
        end
        if (!hit) ans.status = STAT_ABSENT;
      end
      default: begin
        for (int i = 0; i < slot_count; i++) begin
          ax = axis_gap(px, slot_x[i]);
          ay = axis_gap(py, slot_y[i]);
          az = axis_gap(pz, slot_z[i]);
          if (ax <= longint'(rx) && ay <= longint'(ry) && az <= longint'(rz)) begin
            sq = ax * ax + ay * ay + az * az;
            // strict compare keeps the earlier entry on a tie
            if (!ans.found || sq < longint'(ans.dist_sq)) begin
              ans.found = 1'b1;
              ans.handle = slot_handle[i];
              ans.dist_sq = DIST_W'(sq);
            end
          end
        end
      end
    endcase
    return ans;
  endfunction

  function automatic void check_field(input string name, input logic [DIST_W-1:0] exp_val,
                                      input logic [DIST_W-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      slot_count = 0;
      wr_ptr = 0;
      rd_ptr = 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        if (wr_ptr - rd_ptr >= PEND_DEPTH) begin
          $error("too many command transactions pending");
          error_count++;
        end
        expected_answers[wr_ptr % PEND_DEPTH] = apply_command(operation, handle,
                                                              pos_x, pos_y, pos_z,
                                                              range_x, range_y, range_z);
        wr_ptr++;
      end
      if (res_valid && !res_stall) begin
        if (wr_ptr == rd_ptr) begin
          $error("result transaction with no command pending");
          error_count++;
        end else begin
          want = expected_answers[rd_ptr % PEND_DEPTH];
          rd_ptr++;
          check_field("status", DIST_W'(want.status), DIST_W'(status));
          check_field("found", DIST_W'(want.found), DIST_W'(found));
          check_field("nearest_handle", DIST_W'(want.handle), DIST_W'(nearest_handle));
          check_field("nearest_dist_sq", want.dist_sq, nearest_dist_sq);
        end
      end
    end
    outstanding <= wr_ptr - rd_ptr;
  end

endmodule

>>> tb/nearest_point_in_box_table_tb.sv
// testbench top for the nearest point table: clock, reset, command and result traffic, verdict
module nearest_point_in_box_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import npbt_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int SEGMENT_LEN  = 120;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [RANGE_W-1:0]      RANGE_MAX = '1;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cmd_valid;
  logic                       cmd_stall;
  logic [OP_W-1:0]            operation;
  logic [HANDLE_W-1:0]        handle;
  logic signed [POS_W-1:0]    pos_x, pos_y, pos_z;
  logic [RANGE_W-1:0]         range_x, range_y, range_z;
  logic                       res_valid;
  logic                       res_stall;
  logic [STATUS_W-1:0]        status;
  logic                       found;
  logic [HANDLE_W-1:0]        nearest_handle;
  logic [DIST_W-1:0]          nearest_dist_sq;
  int                         outstanding;
  int                         error_count;

  bit                         quiet;
  logic [HANDLE_W-1:0]        recent_h [16];
  logic signed [POS_W-1:0]    recent_x [16];
  logic signed [POS_W-1:0]    recent_y [16];
  logic signed [POS_W-1:0]    recent_z [16];
  int                         recent_fill;
  int                         recent_next;

  nearest_point_in_box_table dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .operation(operation), .handle(handle),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .range_x(range_x), .range_y(range_y), .range_z(range_z),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .found(found),
    .nearest_handle(nearest_handle), .nearest_dist_sq(nearest_dist_sq)
  );

  npbt_checker u_checker (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .operation(operation), .handle(handle),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .range_x(range_x), .range_y(range_y), .range_z(range_z),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .found(found),
    .nearest_handle(nearest_handle), .nearest_dist_sq(nearest_dist_sq),
    .outstanding(outstanding), .error_count(error_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [POS_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return POS_MAX;
      1: return POS_MIN;
      2, 3: return POS_W'($urandom);
      default: return POS_W'(int'($urandom_range(0, 8)) * 16 - 64);
    endcase
  endfunction

  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return RANGE_MAX;
      2: return RANGE_W'($urandom);
      default: return RANGE_W'($urandom_range(0, 160));
    endcase
  endfunction

  task automatic send(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h,
                      input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                      input logic signed [POS_W-1:0] z, input logic [RANGE_W-1:0] rx,
                      input logic [RANGE_W-1:0] ry, input logic [RANGE_W-1:0] rz);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    operation <= op;
    handle    <= h;
    pos_x     <= x;
    pos_y     <= y;
    pos_z     <= z;
    range_x   <= rx;
    range_y   <= ry;
    range_z   <= rz;
    if (op == OP_INSERT) begin
      recent_h[recent_next] = h;
      recent_x[recent_next] = x;
      recent_y[recent_next] = y;
      recent_z[recent_next] = z;
      recent_next = (recent_next + 1) % 16;
      if (recent_fill < 16) recent_fill++;
    end
    do @(posedge clk); while (cmd_stall);
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int n;
    int taken;
    bit held;
    res_stall <= 1'b0;
    taken = 0;
    held = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && taken == HOLD_AT) begin
        held = 1'b1;
        n = HOLD_CYCLES;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 5);
      end
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
      taken++;
    end
  end

  initial begin
    logic [OP_W-1:0]         op;
    logic [HANDLE_W-1:0]     h;
    logic signed [POS_W-1:0] x, y, z;
    logic [RANGE_W-1:0]      rx, ry, rz;
    int                      roll, ins_pct, rem_pct, upd_pct;
    int                      k, ox, oy, oz, handle_span;
    mix_t                    mode;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    operation <= OP_INSERT;
    handle    <= '0;
    pos_x     <= '0;
    pos_y     <= '0;
    pos_z     <= '0;
    range_x   <= '0;
    range_y   <= '0;
    range_z   <= '0;
    quiet = 1'b0;
    recent_fill = 0;
    recent_next = 0;
    mode = MIX_FILL;
    handle_span = 255;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty table, absent handles
    send(OP_QUERY,  8'h00, 0, 0, 0, RANGE_MAX, RANGE_MAX, RANGE_MAX);
    send(OP_REMOVE, 8'h11, 0, 0, 0, 0, 0, 0);
    send(OP_UPDATE, 8'h11, 32, 32, 32, 0, 0, 0);
    // corners, duplicate handle
    send(OP_INSERT, 8'h00, 0, 0, 0, 0, 0, 0);
    send(OP_INSERT, 8'hff, POS_MAX, POS_MAX, POS_MAX, RANGE_MAX, RANGE_MAX, RANGE_MAX);
    send(OP_INSERT, 8'haa, POS_MIN, POS_MIN, POS_MIN, 0, 0, 0);
    send(OP_INSERT, 8'h00, 160, 0, 0, 0, 0, 0);
    // tie sitting on the box edge, then just outside it
    send(OP_QUERY,  8'hff, 80, 0, 0, 80, 0, 0);
    send(OP_QUERY,  8'h00, 81, 0, 0, 80, 0, 0);
    send(OP_QUERY,  8'h5a, POS_MAX, POS_MAX, POS_MAX, 0, 0, 0);
    send(OP_QUERY,  8'h00, POS_MIN, POS_MIN, POS_MIN, RANGE_MAX, RANGE_MAX, RANGE_MAX);
    send(OP_UPDATE, 8'h00, -16, -16, -16, 0, 0, 0);
    send(OP_QUERY,  8'h00, 0, 0, 0, 16, 16, 16);
    send(OP_UPDATE, 8'h55, 0, 0, 0, 0, 0, 0);
    send(OP_REMOVE, 8'h00, 0, 0, 0, 0, 0, 0);
    send(OP_REMOVE, 8'haa, 0, 0, 0, 0, 0, 0);
    send(OP_REMOVE, 8'h55, 0, 0, 0, 0, 0, 0);
    // farthest point that still lies in the box
    send(OP_QUERY,  8'h00, 0, 0, 0, RANGE_MAX, RANGE_MAX, RANGE_MAX);
    send(OP_REMOVE, 8'hff, 0, 0, 0, 0, 0, 0);
    send(OP_QUERY,  8'h00, 0, 0, 0, RANGE_MAX, RANGE_MAX, RANGE_MAX);

    for (int item = 0; item < RANDOM_ITEMS; item++) begin
      if (item % SEGMENT_LEN == 0) begin
        mode = (item == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
        case ($urandom_range(0, 2))
          0: handle_span = 7;
          1: handle_span = 31;
          default: handle_span = 255;
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      case (mode)
        MIX_FILL: begin
          ins_pct = 70; rem_pct = 5; upd_pct = 5;
        end
        MIX_DRAIN: begin
          ins_pct = 15; rem_pct = 45; upd_pct = 15;
        end
        default: begin
          ins_pct = 35; rem_pct = 15; upd_pct = 15;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) op = OP_INSERT;
      else if (roll < ins_pct + rem_pct) op = OP_REMOVE;
      else if (roll < ins_pct + rem_pct + upd_pct) op = OP_UPDATE;
      else op = OP_QUERY;

      if (op != OP_INSERT && recent_fill > 0 && $urandom_range(0, 1) == 1) begin
        h = recent_h[$urandom_range(0, recent_fill - 1)];
      end else begin
        h = HANDLE_W'($urandom_range(0, handle_span));
      end

      if (op == OP_QUERY && recent_fill > 0 && $urandom_range(0, 2) != 0) begin
        k = $urandom_range(0, recent_fill - 1);
        ox = int'($urandom_range(0, 64)) - 32;
        oy = int'($urandom_range(0, 64)) - 32;
        oz = int'($urandom_range(0, 64)) - 32;
        x = POS_W'(recent_x[k] + ox);
        y = POS_W'(recent_y[k] + oy);
        z = POS_W'(recent_z[k] + oz);
        if ($urandom_range(0, 1) == 1) begin
          // box edge lands exactly on the remembered entry
          rx = RANGE_W'((ox < 0) ? -ox : ox);
          ry = RANGE_W'((oy < 0) ? -oy : oy);
          rz = RANGE_W'((oz < 0) ? -oz : oz);
        end else begin
          rx = pick_range();
          ry = pick_range();
          rz = pick_range();
        end
      end else begin
        x = pick_coord();
        y = pick_coord();
        z = pick_coord();
        if (op == OP_QUERY) begin
          rx = pick_range();
          ry = pick_range();
          rz = pick_range();
        end else begin
          rx = RANGE_W'($urandom);
          ry = RANGE_W'($urandom);
          rz = RANGE_W'($urandom);
        end
      end
      send(op, h, x, y, z, rx, ry, rz);
    end

    cmd_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/npbt_pkg.sv
rtl/core/npbt_cell.sv
rtl/core/npbt_scan.sv
rtl/core/nearest_point_in_box_table.sv
tb/npbt_checker.sv
tb/nearest_point_in_box_table_tb.sv
